FILE: design/etcr_pkg.sv
// ----------------------------------------------------------------------------
// etcr_pkg
// Shared types and constants for the elapsed tick compare reload block.
// ----------------------------------------------------------------------------
package etcr_pkg;

  // counter and divider word width
  localparam int unsigned WORD_W   = 32;
  // number of restoring division steps, one quotient bit each
  localparam int unsigned DIV_STEPS = WORD_W;
  localparam int unsigned STEP_W   = $clog2(DIV_STEPS);

  // result payload widths
  localparam int unsigned OUT_DATA_W = 2 * WORD_W;
  localparam int unsigned OUT_USER_W = 2;

  // configuration register file
  localparam int unsigned ADDR_W  = 3;
  localparam logic        REG_COUNTS_PER_TICK = 1'b0;
  localparam logic [WORD_W-1:0] CPT_RESET = 32'd32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic start;  // capture sample and compute elapsed counts
    logic step;   // one division step
    logic load;   // write the result register and update last compare
  } etcr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } etcr_status_t;

endpackage

FILE: design/etcr_ctrl.sv
// ----------------------------------------------------------------------------
// etcr_ctrl
// Sequencer: accepts a sample, runs the division steps when a compare is
// pending, then hands the result to the output register once it has room.
// ----------------------------------------------------------------------------
module etcr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_pend,
  output logic                 in_ready,
  input  etcr_pkg::etcr_status_t status,
  output etcr_pkg::etcr_cmd_t    cmd
);
  import etcr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] count;
  logic [STEP_W-1:0] count_next;
  logic              last_step;

  assign last_step = (count == STEP_W'(DIV_STEPS - 1));
  assign in_ready  = (state == ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          count_next = '0;
          // no pending event skips the divider
          state_next = in_pend ? ST_DIV : ST_LOAD;
        end
      end
      ST_DIV: begin
        cmd.step   = 1'b1;
        count_next = count + STEP_W'(1);
        if (last_step) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

FILE: design/etcr_datapath.sv
// ----------------------------------------------------------------------------
// etcr_datapath
// Elapsed count, restoring divider, last compare state, divisor register
// and the output register.
// ----------------------------------------------------------------------------
module etcr_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  etcr_pkg::etcr_cmd_t                  cmd,
  output etcr_pkg::etcr_status_t               status,
  input  logic [etcr_pkg::WORD_W-1:0]          in_counter,
  input  logic                                 in_pend,
  input  logic                                 cfg_we,
  input  logic [etcr_pkg::WORD_W-1:0]          cfg_wdata,
  output logic [etcr_pkg::WORD_W-1:0]          cpt,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [etcr_pkg::OUT_DATA_W-1:0]      out_data,
  output logic [etcr_pkg::OUT_USER_W-1:0]      out_user
);
  import etcr_pkg::*;

  logic [WORD_W-1:0] last_compare;
  logic [WORD_W-1:0] cur;
  logic              pend;
  logic [WORD_W-1:0] rem;
  logic [WORD_W-1:0] quo;
  logic [WORD_W-1:0] elapsed;
  logic [WORD_W:0]   trial;
  logic              fits;

  assign status.out_free = !out_valid || out_ready;

  // elapsed counts; the wrap case stays one count short
  assign elapsed = (in_counter < last_compare) ? (in_counter + ~last_compare)
                                               : (in_counter - last_compare);

  // restoring step: shift in the next dividend bit and try the divisor
  assign trial = {rem, quo[WORD_W-1]};
  assign fits  = (trial >= {1'b0, cpt});

  // divisor register
  always_ff @(posedge clk) begin
    if (rst) begin
      cpt <= CPT_RESET;
    end else if (cfg_we) begin
      cpt <= cfg_wdata;
    end
  end

  // sample capture and divider
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur  <= in_counter;
      pend <= in_pend;
      quo  <= elapsed;
      rem  <= '0;
    end else if (cmd.step) begin
      quo <= {quo[WORD_W-2:0], fits};
      rem <= fits ? (trial[WORD_W-1:0] - cpt) : trial[WORD_W-1:0];
    end
  end

  // last compare moves back by the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      last_compare <= '0;
    end else if (cmd.load && pend) begin
      last_compare <= cur - rem;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload, all zeros when nothing was pending
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (pend) begin
        out_data <= {cpt - rem, quo};
        out_user <= {1'b1, 1'b1};
      end else begin
        out_data <= '0;
        out_user <= '0;
      end
    end
  end

endmodule

FILE: design/elapsed_tick_compare_reload_core.sv
// ----------------------------------------------------------------------------
// elapsed_tick_compare_reload_core
// Tick timer compare service: elapsed ticks since last compare, next compare
// delta and last compare update from each counter sample.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+----------------------------------
//   s_*       | in  | s_tvalid/s_tready  | counter sample, pending flag
//   m_*       | out | m_tvalid/m_tready  | ticks, delta, dispatched, clear
//   apb       | in  | psel/penable       | counts_per_tick at address 0
//
// A pending sample: capture and elapsed count, 32 restoring division
// steps, then a load once the result register has room.
// A sample with no pending event skips the division steps.
// A new sample is taken once the previous one is in the result register,
// even while that result still waits for m_tready.
// Reset (rst, synchronous) sets counts_per_tick to 32 and last compare to 0.
// ----------------------------------------------------------------------------
module elapsed_tick_compare_reload_core (
  input  logic                            clk,
  input  logic                            rst,
  // stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,   // [31:0] counter_value
  input  logic [0:0]                      s_tuser,   // [0] compare_pending
  // stream out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [63:0]                     m_tdata,   // [31:0] ticks_elapsed,
                                                     // [63:32] compare_delta
  output logic [1:0]                      m_tuser,   // [0] dispatched,
                                                     // [1] clear_pending
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [etcr_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import etcr_pkg::*;

  etcr_cmd_t         cmd;
  etcr_status_t      status;
  logic              cfg_we;
  logic [WORD_W-1:0] cpt;
  logic              in_acc_valid;

  // register decode, word index in paddr[2]
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_COUNTS_PER_TICK);
  assign prdata = (paddr[2] == REG_COUNTS_PER_TICK) ? cpt : '0;

  assign in_acc_valid = s_tvalid;

  etcr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_acc_valid),
    .in_pend  (s_tuser[0]),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  etcr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .in_counter (s_tdata),
    .in_pend    (s_tuser[0]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (pwdata),
    .cpt        (cpt),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_user   (m_tuser)
  );

endmodule

FILE: design/etcr_checker.sv
// ----------------------------------------------------------------------------
// etcr_checker
// Port level checks for the elapsed tick compare reload core.
// ----------------------------------------------------------------------------
module etcr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a transfer in closes the input until the result is formed
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after a transfer");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // dispatched and clear request always go together
  a_flags_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[0] == m_tuser[1])
    else $error("dispatched and clear_pending differ");

  // a result with no dispatched event carries zeros
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0)
    else $error("non-dispatched result not zero");

endmodule

bind elapsed_tick_compare_reload_core etcr_checker u_etcr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

FILE: bench/tb_elapsed_tick_compare_reload_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_elapsed_tick_compare_reload_core
// Self-checking bench for the tick timer compare reload block. Counter samples
// stream in through a bursty driver and results are drained by a receiver
// that stalls on its own pattern. Each accepted sample is run through a local
// model of the elapsed-count, divide and reload step, and every result
// transfer is checked field by field against the oldest prediction. The tick
// divisor is swept over several settings, the extremes and zero among them.
// ----------------------------------------------------------------------------
module tb_elapsed_tick_compare_reload_core;
  import etcr_pkg::*;

  localparam logic [WORD_W-1:0] ALL_ONES = '1;
  localparam logic [ADDR_W-1:0] CPT_ADDR = ADDR_W'(4 * REG_COUNTS_PER_TICK);
  // first address past the register file, writes there must be ignored
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4 * (REG_COUNTS_PER_TICK + 1));
  localparam int unsigned LATENCY = 34;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned PHASE_ITEMS = 88;
  localparam int unsigned DRAIN_LIMIT = 20000;

  typedef struct packed {
    logic [WORD_W-1:0] counter;
    logic              pending;
  } tick_sample_t;

  typedef struct packed {
    logic              dispatched;
    logic [WORD_W-1:0] ticks;
    logic [WORD_W-1:0] delta;
    logic              clear;
  } tick_result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] counter_value
  logic [0:0]  s_tuser = '0;   // [0] compare_pending
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] ticks_elapsed, [63:32] compare_delta
  logic [1:0]  m_tuser;        // [0] dispatched, [1] clear_pending
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // local copy of block state and divisor
  logic [WORD_W-1:0] tick_last_cmp = '0;
  logic [WORD_W-1:0] tick_cpt = CPT_RESET;

  tick_sample_t sample_q[$];
  tick_result_t reload_q[$];
  int unsigned  mismatch_count = 0;
  logic         in_taken = 1'b0;

  // sender burst shaping
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;

  // receiver stall pattern and long hold-off
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_cnt = 0;
  int unsigned mode_cnt = 0;
  int unsigned rx_phase = 0;
  rx_mode_t    rx_mode = RX_OPEN;

  logic [WORD_W-1:0] gen_cnt = '0;

  elapsed_tick_compare_reload_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial forever #5 clk = ~clk;

  // elapsed counts, divide into ticks, move last compare back by the remainder
  function automatic tick_result_t predict_reload(input logic [WORD_W-1:0] cnt,
                                                  input logic pend);
    tick_result_t      r;
    logic [WORD_W-1:0] elapsed;
    logic [WORD_W-1:0] quot;
    logic [WORD_W-1:0] rem;
    r = '0;
    if (pend) begin
      // wrap keeps the one-count shortfall of the original handler
      if (cnt < tick_last_cmp) elapsed = cnt + (ALL_ONES - tick_last_cmp);
      else elapsed = cnt - tick_last_cmp;
      if (tick_cpt == '0) begin
        quot = ALL_ONES;
        rem = elapsed;
      end else begin
        quot = elapsed / tick_cpt;
        rem = elapsed - tick_cpt * quot;
      end
      tick_last_cmp = cnt - rem;
      r.dispatched = 1'b1;
      r.ticks = quot;
      r.delta = tick_cpt - rem;
      r.clear = 1'b1;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %h, got %h", $realtime, what, want, got);
  endtask

  function automatic void queue_sample(input logic [WORD_W-1:0] cnt, input logic pend);
    sample_q.push_back('{counter: cnt, pending: pend});
  endfunction

  // register write followed by a read-back of the divisor
  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == CPT_ADDR) tick_cpt = data;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= CPT_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== tick_cpt)
      flag_mismatch("counts_per_tick read-back", 64'(tick_cpt), 64'(prdata));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // every sample taken and every result back
  task automatic wait_idle;
    while (sample_q.size() != 0 || s_tvalid || reload_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // input driver: bursts of transfers with random gaps
  always @(negedge clk) begin
    tick_sample_t item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // still on offer, hold it
    end else if (gap_left != 0) begin
      s_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (sample_q.size() != 0) begin
      item = sample_q.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= item.counter;
      s_tuser <= item.pending;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        gap_left <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result receiver: long hold-off on request, else a changing stall pattern
  always @(negedge clk) begin
    rx_phase <= rx_phase + 1;
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_cnt <= LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      if (mode_cnt == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_cnt <= $urandom_range(20, 200);
      end else begin
        mode_cnt <= mode_cnt - 1;
      end
      case (rx_mode)
        RX_OPEN:     m_tready <= 1'b1;
        RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE:   m_tready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: m_tready <= ((rx_phase % 7) < 3);
        default:     m_tready <= 1'b1;
      endcase
    end
  end

  // monitor: check result transfers, then predict from input transfers
  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.dispatched = m_tuser[0];
        got.clear = m_tuser[1];
        got.ticks = m_tdata[31:0];
        got.delta = m_tdata[63:32];
        if (reload_q.size() == 0) begin
          flag_mismatch("result with none outstanding", '0, m_tdata);
        end else begin
          want = reload_q.pop_front();
          if (got.dispatched !== want.dispatched)
            flag_mismatch("dispatched", 64'(want.dispatched), 64'(got.dispatched));
          if (got.ticks !== want.ticks)
            flag_mismatch("ticks_elapsed", 64'(want.ticks), 64'(got.ticks));
          if (got.delta !== want.delta)
            flag_mismatch("compare_delta", 64'(want.delta), 64'(got.delta));
          if (got.clear !== want.clear)
            flag_mismatch("clear_pending", 64'(want.clear), 64'(got.clear));
        end
      end
      if (s_tvalid && s_tready) reload_q.push_back(predict_reload(s_tdata, s_tuser[0]));
    end
  end

  // stimulus sequence
  initial begin
    logic [63:0]       adv;
    logic [WORD_W-1:0] phase_cpt [8];
    int unsigned       pick;
    int unsigned       drain;

    phase_cpt[0] = CPT_RESET;
    phase_cpt[1] = 32'd1;
    phase_cpt[2] = ALL_ONES;
    phase_cpt[3] = '0;
    phase_cpt[4] = 32'd10;
    phase_cpt[5] = $urandom;
    phase_cpt[6] = $urandom_range(2, 100);
    phase_cpt[7] = 32'h8000_0000;

    repeat (2) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // reset divisor: idle samples, zero elapsed, remainder edges, wrap
    @(posedge clk);
    queue_sample(32'h0000_0000, 1'b0);
    queue_sample(ALL_ONES, 1'b0);
    queue_sample(32'h0000_0000, 1'b1);
    queue_sample(32'd31, 1'b1);
    queue_sample(32'd32, 1'b1);
    queue_sample(32'd32, 1'b1);
    queue_sample(ALL_ONES, 1'b1);
    queue_sample(32'd5, 1'b1);
    queue_sample(32'd5, 1'b0);
    queue_sample(32'hAAAA_AAAA, 1'b1);
    queue_sample(32'h5555_5555, 1'b1);
    wait_idle();

    // divisor of one, then a write to an unmapped address
    apb_write(CPT_ADDR, 32'd1);
    @(posedge clk);
    queue_sample(32'd100, 1'b1);
    queue_sample(32'd0, 1'b1);
    queue_sample(ALL_ONES, 1'b1);
    wait_idle();
    apb_write(SPARE_ADDR, 32'd0);

    // largest divisor
    apb_write(CPT_ADDR, ALL_ONES);
    @(posedge clk);
    queue_sample(32'hFFFF_FFFE, 1'b1);
    queue_sample(ALL_ONES, 1'b1);
    queue_sample(32'd0, 1'b1);
    queue_sample(32'd1, 1'b1);
    wait_idle();

    // divisor of zero behaves as a plain restoring divider
    apb_write(CPT_ADDR, '0);
    @(posedge clk);
    queue_sample(32'd10, 1'b1);
    queue_sample(32'd3, 1'b1);
    queue_sample(ALL_ONES, 1'b1);
    queue_sample(32'd0, 1'b0);
    wait_idle();

    // random phases, one divisor each
    for (int p = 0; p < 8; p++) begin
      apb_write(CPT_ADDR, phase_cpt[p]);
      @(posedge clk);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // realistic advance of a few ticks plus jitter
          adv = 64'(tick_cpt) * $urandom_range(0, 3)
              + ((tick_cpt == '0) ? $urandom_range(0, 1000) : $urandom_range(0, tick_cpt));
          gen_cnt = gen_cnt + adv[WORD_W-1:0];
        end else if (pick < 80) begin
          gen_cnt = $urandom;
        end else if (pick < 90) begin
          gen_cnt = ($urandom_range(0, 1) != 0) ? ALL_ONES - $urandom_range(0, 64)
                                                : $urandom_range(0, 64);
        end
        queue_sample(gen_cnt, $urandom_range(0, 99) < 80);
      end
      // receiver holds off while the sender keeps offering
      if (p == 1 || p == 5) begin
        @(posedge clk);
        hold_req = hold_req + 1;
      end
      wait_idle();
    end

    // drain and let the pipeline settle
    drain = 0;
    while (reload_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (LATENCY + 6) @(negedge clk);
    if (reload_q.size() != 0) flag_mismatch("results missing", '0, 64'(reload_q.size()));

    if (mismatch_count == 0) begin
      $display("elapsed_tick_compare_reload_core: match");
    end else begin
      $display("elapsed_tick_compare_reload_core: mismatch");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("elapsed_tick_compare_reload_core: mismatch");
    $finish;
  end

endmodule
